// ===== design/assert_macros.svh =====
// assertion macros used by the port-level checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every rising clock edge outside reset
`define ASSERT_ALWAYS(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// consequence checked in the cycle after the trigger
`define ASSERT_NEXT(label, clk, rst, trig, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cons)) else $error(msg);

`endif

// ===== design/mma_pkg.sv =====
// types and constants of the montgomery modular alu
package mma_pkg;

   localparam logic [29:0] MODULUS_RESET = 30'd998244353;
   localparam int NEWTON_STEPS = 4;
   localparam int R2_STEPS     = 65;
   localparam int REM_STEPS    = 64;

   typedef enum logic [3:0] {
      CMD_FROM_PLAIN = 4'd0,
      CMD_TO_PLAIN   = 4'd1,
      CMD_ADD        = 4'd2,
      CMD_SUB        = 4'd3,
      CMD_MUL        = 4'd4,
      CMD_DIV        = 4'd5,
      CMD_NEG        = 4'd6,
      CMD_POW        = 4'd7,
      CMD_INVERSE    = 4'd8,
      CMD_EQUAL      = 4'd9
   } cmd_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_INV,
      ST_R2,
      ST_DECODE,
      ST_REM,
      ST_REM_FIX,
      ST_MP0,
      ST_MP1,
      ST_MP2,
      ST_MP3,
      ST_CANON,
      ST_POW_STEP,
      ST_ALU,
      ST_WRAP,
      ST_DONE
   } state_type;

   // what a finished montgomery product feeds
   typedef enum logic [2:0] {
      PH_PLAIN,
      PH_TO_PLAIN,
      PH_FINAL,
      PH_POW_INIT,
      PH_POW_ACC,
      PH_POW_SQ
   } phase_type;

endpackage

// ===== design/montgomery_mod_alu_top.sv =====
// montgomery modular alu, R = 2^32, odd modulus below 2^30
// Usage: a command word (req_cmd and its operands) is taken at a rising edge where start
// is high and busy is low. busy stays high until the result word has been shown. The
// result stands on rsp_value / rsp_equal for exactly one cycle, marked by rsp_valid,
// and busy drops in the next cycle. The receiver cannot stall; it must take the word.
// csr_wr_en / csr_wr_data write the modulus (bit 0 forced to 1); the user must write it
// only while the block is idle, as the block does not enforce it. After reset or a write,
// the first command derives the constants: newton steps for the modulus inverse, then
// 2^64 mod modulus. Products share one 32x32 multiplier, remainders one compare-subtract
// unit; each montgomery product runs through the states MP0, MP1, MP2 and MP3. Per command:
//   add, sub, neg: alu step, then 2m wrap fix; equal and unknown commands: decode only
//   mul: one product; to_plain: one product, then one conditional subtract of m
//   from_plain: bit-serial remainder of the 64-bit magnitude, then one product
//   pow: square per exponent bit, multiply per set bit; inverse and div: exponent modulus-2
// Reset is synchronous and active high: the modulus returns to 998244353, the block
// goes idle and the derived constants are rebuilt before the next command.
module montgomery_mod_alu_top (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [3:0]         req_cmd,
   input  logic [30:0]        req_operand_a,
   input  logic [30:0]        req_operand_b,
   input  logic signed [63:0] req_plain_value,
   input  logic [63:0]        req_exponent,
   input  logic               csr_wr_en,
   input  logic [29:0]        csr_wr_data,
   output logic               rsp_valid,
   output logic [30:0]        rsp_value,
   output logic               rsp_equal
);
   import mma_pkg::*;

   localparam logic [6:0] NEWTON_LAST = 7'(NEWTON_STEPS - 1);
   localparam logic [6:0] R2_LAST     = 7'(R2_STEPS - 1);
   localparam logic [6:0] REM_LAST    = 7'(REM_STEPS - 1);

   state_type   state_ff, state_in;
   phase_type   phase_ff;
   cmd_type     cmd_ff;
   logic [29:0] modulus_ff;
   logic        dirty_ff;
   logic [30:0] a_ff, b_ff;
   logic [63:0] plain_ff;
   logic [63:0] exp_ff;
   logic [31:0] inv_ff, nneg_ff;
   logic [29:0] r2_ff, rem_ff;
   logic [63:0] src_ff;
   logic        neg_ff;
   logic [6:0]  cnt_ff;
   logic [1:0]  sub_ff;
   logic [63:0] prod_ff, x_ff;
   logic [31:0] op_x_ff, op_y_ff;
   logic [31:0] acc_ff, sq_ff;
   logic [31:0] value_ff;
   logic        eq_ff;
   logic        div_ff;

   logic [31:0] m32, two_m, one_m, inv_exp, fix_t;
   logic [31:0] mul_a, mul_b;
   logic [63:0] prod_in;
   logic        rem_bit;
   logic [30:0] rem_d, rem_sub;
   logic [29:0] rem_next;
   logic [64:0] redc_sum;
   logic [31:0] redc_res;
   logic [30:0] a_canon, b_canon;
   logic [63:0] plain_mag;

   assign m32     = {2'b00, modulus_ff};
   assign two_m   = {1'b0, modulus_ff, 1'b0};
   // montgomery form of one: (1 mod m + m) * r2 goes through one product
   assign one_m   = m32 + ((modulus_ff != 30'd1) ? 32'd1 : 32'd0);
   assign inv_exp = m32 - 32'd2;
   assign fix_t   = (neg_ff && (rem_ff != 30'd0)) ? (m32 - {2'b00, rem_ff})
                                                  : ({2'b00, rem_ff} + m32);

   // shared multiplier, product registered every cycle
   assign prod_in = mul_a * mul_b;

   // shared compare-subtract, one remainder bit per cycle
   assign rem_d    = {rem_ff, rem_bit};
   assign rem_sub  = rem_d - {1'b0, modulus_ff};
   assign rem_next = (rem_d >= {1'b0, modulus_ff}) ? rem_sub[29:0] : rem_d[29:0];

   assign redc_sum = {1'b0, x_ff} + {1'b0, prod_ff};
   assign redc_res = redc_sum[63:32];

   assign a_canon   = (a_ff >= {1'b0, modulus_ff}) ? (a_ff - {1'b0, modulus_ff}) : a_ff;
   assign b_canon   = (b_ff >= {1'b0, modulus_ff}) ? (b_ff - {1'b0, modulus_ff}) : b_ff;
   assign plain_mag = plain_ff[63] ? (64'd0 - plain_ff) : plain_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = dirty_ff ? ST_INV : ST_DECODE;
            end
         end
         ST_INV: begin
            if (sub_ff == 2'd3 && cnt_ff == NEWTON_LAST) begin
               state_in = ST_R2;
            end
         end
         ST_R2: begin
            if (cnt_ff == R2_LAST) begin
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            unique case (cmd_ff) inside
               CMD_FROM_PLAIN: state_in = ST_REM;
               CMD_ADD, CMD_SUB, CMD_NEG: state_in = ST_ALU;
               CMD_TO_PLAIN, CMD_MUL, CMD_POW, CMD_INVERSE, CMD_DIV: state_in = ST_MP0;
               default: state_in = ST_DONE;
            endcase
         end
         ST_REM: begin
            if (cnt_ff == REM_LAST) begin
               state_in = ST_REM_FIX;
            end
         end
         ST_REM_FIX: state_in = ST_MP0;
         ST_MP0:     state_in = ST_MP1;
         ST_MP1:     state_in = ST_MP2;
         ST_MP2:     state_in = ST_MP3;
         ST_MP3: begin
            case (phase_ff) inside
               PH_TO_PLAIN:             state_in = ST_CANON;
               PH_POW_INIT, PH_POW_SQ:  state_in = ST_POW_STEP;
               PH_POW_ACC:              state_in = ST_MP0;
               default:                 state_in = ST_DONE;
            endcase
         end
         ST_CANON: state_in = ST_DONE;
         ST_POW_STEP: begin
            if (exp_ff == 64'd0) begin
               state_in = div_ff ? ST_MP0 : ST_DONE;
            end else begin
               state_in = ST_MP0;
            end
         end
         ST_ALU:  state_in = ST_WRAP;
         ST_WRAP: state_in = ST_DONE;
         ST_DONE: state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // unit selects of the multiplier and the remainder unit
   always_comb begin
      mul_a   = '0;
      mul_b   = '0;
      rem_bit = 1'b0;
      unique case (state_ff)
         ST_INV: begin
            if (sub_ff == 2'd0) begin
               mul_a = m32;
               mul_b = inv_ff;
            end else if (sub_ff == 2'd2) begin
               mul_a = inv_ff;
               mul_b = op_y_ff;
            end
         end
         ST_R2:  rem_bit = (cnt_ff == 7'd0);
         ST_REM: rem_bit = src_ff[63];
         ST_MP0: begin
            mul_a = op_x_ff;
            mul_b = op_y_ff;
         end
         ST_MP1: begin
            mul_a = prod_ff[31:0];
            mul_b = nneg_ff;
         end
         ST_MP2: begin
            mul_a = prod_ff[31:0];
            mul_b = m32;
         end
         default: ;
      endcase
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = (state_ff == ST_DONE);
   assign rsp_value = value_ff[30:0];
   assign rsp_equal = eq_ff;

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         modulus_ff <= MODULUS_RESET;
         dirty_ff   <= 1'b1;
      end else begin
         state_ff <= state_in;
         if (csr_wr_en) begin
            modulus_ff <= {csr_wr_data[29:1], 1'b1};
            dirty_ff   <= 1'b1;
         end else if (state_ff == ST_R2 && cnt_ff == R2_LAST) begin
            dirty_ff <= 1'b0;
         end
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd_ff   <= cmd_type'(req_cmd);
               a_ff     <= req_operand_a;
               b_ff     <= req_operand_b;
               plain_ff <= req_plain_value;
               exp_ff   <= req_exponent;
               inv_ff   <= m32;
               cnt_ff   <= '0;
               sub_ff   <= '0;
            end
         end
         ST_INV: begin
            // x <- x * (2 - m*x), four substeps per newton step
            sub_ff <= sub_ff + 2'd1;
            if (sub_ff == 2'd1) begin
               op_y_ff <= 32'd2 - prod_ff[31:0];
            end
            if (sub_ff == 2'd3) begin
               inv_ff  <= prod_ff[31:0];
               nneg_ff <= 32'd0 - prod_ff[31:0];
               if (cnt_ff == NEWTON_LAST) begin
                  cnt_ff <= '0;
                  rem_ff <= '0;
               end else begin
                  cnt_ff <= cnt_ff + 7'd1;
               end
            end
         end
         ST_R2: begin
            // 2^64 mod m: a one then 64 zeros through the remainder unit
            rem_ff <= rem_next;
            cnt_ff <= cnt_ff + 7'd1;
            if (cnt_ff == R2_LAST) begin
               r2_ff <= rem_next;
            end
         end
         ST_DECODE: begin
            value_ff <= '0;
            eq_ff    <= (cmd_ff == CMD_EQUAL) && (a_canon == b_canon);
            div_ff   <= (cmd_ff == CMD_DIV);
            cnt_ff   <= '0;
            rem_ff   <= '0;
            src_ff   <= plain_mag;
            neg_ff   <= plain_ff[63];
            unique case (cmd_ff) inside
               CMD_TO_PLAIN: begin
                  op_x_ff  <= {1'b0, a_ff};
                  op_y_ff  <= 32'd1;
                  phase_ff <= PH_TO_PLAIN;
               end
               CMD_MUL: begin
                  op_x_ff  <= {1'b0, a_ff};
                  op_y_ff  <= {1'b0, b_ff};
                  phase_ff <= PH_FINAL;
               end
               CMD_POW: begin
                  op_x_ff  <= one_m;
                  op_y_ff  <= {2'b00, r2_ff};
                  phase_ff <= PH_POW_INIT;
                  sq_ff    <= {1'b0, a_ff};
               end
               CMD_INVERSE: begin
                  op_x_ff  <= one_m;
                  op_y_ff  <= {2'b00, r2_ff};
                  phase_ff <= PH_POW_INIT;
                  sq_ff    <= {1'b0, a_ff};
                  exp_ff   <= {32'd0, inv_exp};
               end
               CMD_DIV: begin
                  op_x_ff  <= one_m;
                  op_y_ff  <= {2'b00, r2_ff};
                  phase_ff <= PH_POW_INIT;
                  sq_ff    <= {1'b0, b_ff};
                  exp_ff   <= {32'd0, inv_exp};
               end
               default: ;
            endcase
         end
         ST_REM: begin
            rem_ff <= rem_next;
            src_ff <= {src_ff[62:0], 1'b0};
            cnt_ff <= cnt_ff + 7'd1;
         end
         ST_REM_FIX: begin
            // truncated remainder plus modulus, then times r2
            op_x_ff  <= fix_t;
            op_y_ff  <= {2'b00, r2_ff};
            phase_ff <= PH_PLAIN;
         end
         ST_MP1: x_ff <= prod_ff;
         ST_MP3: begin
            case (phase_ff) inside
               PH_PLAIN, PH_TO_PLAIN, PH_FINAL: value_ff <= redc_res;
               PH_POW_INIT: acc_ff <= redc_res;
               PH_POW_ACC: begin
                  acc_ff   <= redc_res;
                  op_x_ff  <= sq_ff;
                  op_y_ff  <= sq_ff;
                  phase_ff <= PH_POW_SQ;
               end
               PH_POW_SQ: begin
                  sq_ff  <= redc_res;
                  exp_ff <= {1'b0, exp_ff[63:1]};
               end
               default: ;
            endcase
         end
         ST_CANON: begin
            if (value_ff >= m32) begin
               value_ff <= value_ff - m32;
            end
         end
         ST_POW_STEP: begin
            if (exp_ff == 64'd0) begin
               if (div_ff) begin
                  op_x_ff  <= {1'b0, a_ff};
                  op_y_ff  <= acc_ff;
                  phase_ff <= PH_FINAL;
               end else begin
                  value_ff <= acc_ff;
               end
            end else if (exp_ff[0]) begin
               op_x_ff  <= acc_ff;
               op_y_ff  <= sq_ff;
               phase_ff <= PH_POW_ACC;
            end else begin
               op_x_ff  <= sq_ff;
               op_y_ff  <= sq_ff;
               phase_ff <= PH_POW_SQ;
            end
         end
         ST_ALU: begin
            case (cmd_ff)
               CMD_ADD: value_ff <= {1'b0, a_ff} + {1'b0, b_ff} - two_m;
               CMD_SUB: value_ff <= {1'b0, a_ff} - {1'b0, b_ff};
               CMD_NEG: value_ff <= 32'd0 - {1'b0, a_ff};
               default: value_ff <= '0;
            endcase
         end
         ST_WRAP: begin
            // wrapped below zero: add 2m once
            if (value_ff[31]) begin
               value_ff <= value_ff + two_m;
            end
         end
         default: ;
      endcase
   end

endmodule

// ===== design/mma_checker.sv =====
// port-level checks of the montgomery modular alu and their bind
`include "assert_macros.svh"

module mma_sva (
   input logic               clock,
   input logic               reset,
   input logic               start,
   input logic               busy,
   input logic [3:0]         req_cmd,
   input logic [30:0]        req_operand_a,
   input logic [30:0]        req_operand_b,
   input logic signed [63:0] req_plain_value,
   input logic [63:0]        req_exponent,
   input logic               csr_wr_en,
   input logic [29:0]        csr_wr_data,
   input logic               rsp_valid,
   input logic [30:0]        rsp_value,
   input logic               rsp_equal
);

   `ASSERT_NEXT(a_accept_busy, clock, reset, start && !busy, busy, "busy not raised")
   `ASSERT_NEXT(a_rsp_idle, clock, reset, rsp_valid, !busy && !rsp_valid, "busy after word")
   `ASSERT_ALWAYS(a_eq_zero, clock, reset, rsp_valid && rsp_equal |-> rsp_value == '0, "eq value")
   `ASSERT_ALWAYS(a_late, clock, reset, rsp_valid |-> busy && !$past(start && !busy), "early word")

endmodule

bind montgomery_mod_alu_top mma_sva u_mma_sva (.*);

// ===== tb/sv/mma_checker.sv =====
`timescale 1ns / 100ps
// checker for the montgomery modular alu: predicts every result word and compares it
module mma_checker (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic               busy,
   input  logic [3:0]         req_cmd,
   input  logic [30:0]        req_operand_a,
   input  logic [30:0]        req_operand_b,
   input  logic signed [63:0] req_plain_value,
   input  logic [63:0]        req_exponent,
   input  logic               csr_wr_en,
   input  logic [29:0]        csr_wr_data,
   input  logic               rsp_valid,
   input  logic [30:0]        rsp_value,
   input  logic               rsp_equal,
   output int                 error_count,
   output int                 pending_count,
   output int                 checked_count
);
   import mma_pkg::*;

   typedef struct packed {
      logic [30:0] value;
      logic        equal;
   } alu_word_type;

   alu_word_type predicted_words[$];
   logic [31:0]  cur_mod;
   logic [31:0]  mod_inv;
   logic [31:0]  r_sq;

   initial begin
      error_count   = 0;
      pending_count = 0;
      checked_count = 0;
   end

   task automatic load_modulus(input logic [29:0] wr);
      logic [31:0] x;
      begin
         cur_mod = {2'b00, wr[29:1], 1'b1};
         x = cur_mod;
         for (int i = 0; i < NEWTON_STEPS; i++) begin
            x = x * (32'd2 - cur_mod * x);
         end
         mod_inv = x;
         r_sq = 32'((64'd0 - {32'd0, cur_mod}) % {32'd0, cur_mod});
      end
   endtask

   function automatic logic [31:0] mont_reduce(input logic [63:0] x);
      logic [31:0] m;
      logic [63:0] s;
      begin
         m = x[31:0] * (32'd0 - mod_inv);
         s = x + {32'd0, m} * {32'd0, cur_mod};
         return s[63:32];
      end
   endfunction

   function automatic logic [31:0] mont_mul(input logic [31:0] a, input logic [31:0] b);
      return mont_reduce({32'd0, a} * {32'd0, b});
   endfunction

   function automatic logic [31:0] plain_to_mont(input logic signed [63:0] v);
      longint      m;
      longint      t;
      logic [63:0] tu;
      begin
         m = longint'(cur_mod);
         t = v % m + m;
         tu = t;
         return mont_reduce(tu * {32'd0, r_sq});
      end
   endfunction

   function automatic logic [31:0] mont_pow(input logic [31:0] base, input logic [63:0] e);
      logic [31:0] acc;
      logic [31:0] sq;
      logic [63:0] n;
      begin
         acc = plain_to_mont(64'sd1);
         sq = base;
         n = e;
         while (n != 64'd0) begin
            if (n[0]) begin
               acc = mont_mul(acc, sq);
            end
            sq = mont_mul(sq, sq);
            n = n >> 1;
         end
         return acc;
      end
   endfunction

   // lazy correction: a wrapped difference gets 2*modulus back once
   function automatic logic [31:0] wrap_fix(input logic [31:0] s);
      return s[31] ? s + (cur_mod << 1) : s;
   endfunction

   function automatic logic [31:0] canon(input logic [31:0] a);
      return (a >= cur_mod) ? a - cur_mod : a;
   endfunction

   function automatic alu_word_type alu_outcome(input logic [3:0] cmd,
                                                input logic [30:0] op_a,
                                                input logic [30:0] op_b,
                                                input logic signed [63:0] plain,
                                                input logic [63:0] e);
      logic [31:0]  a;
      logic [31:0]  b;
      logic [31:0]  v;
      alu_word_type w;
      begin
         a = {1'b0, op_a};
         b = {1'b0, op_b};
         v = 32'd0;
         w.equal = 1'b0;
         case (cmd)
            CMD_FROM_PLAIN: v = plain_to_mont(plain);
            CMD_TO_PLAIN:   v = canon(mont_reduce({32'd0, a}));
            CMD_ADD:        v = wrap_fix(a + b - (cur_mod << 1));
            CMD_SUB:        v = wrap_fix(a - b);
            CMD_MUL:        v = mont_mul(a, b);
            CMD_DIV:        v = mont_mul(a, mont_pow(b, {32'd0, cur_mod - 32'd2}));
            CMD_NEG:        v = wrap_fix(32'd0 - a);
            CMD_POW:        v = mont_pow(a, e);
            CMD_INVERSE:    v = mont_pow(a, {32'd0, cur_mod - 32'd2});
            CMD_EQUAL:      w.equal = (canon(a) == canon(b));
            default: ;
         endcase
         w.value = v[30:0];
         return w;
      end
   endfunction

   always @(posedge clock) begin : watch
      alu_word_type want;
      if (reset) begin
         load_modulus(MODULUS_RESET);
      end else begin
         if (csr_wr_en) begin
            load_modulus(csr_wr_data);
         end
         if (start && !busy) begin
            predicted_words.push_back(alu_outcome(req_cmd, req_operand_a, req_operand_b,
                                                  req_plain_value, req_exponent));
         end
         if (rsp_valid) begin
            if (predicted_words.size() == 0) begin
               error_count++;
               $display("%0t: result word with none expected, actual value %h equal %b",
                        $time, rsp_value, rsp_equal);
            end else begin
               want = predicted_words.pop_front();
               checked_count++;
               if (rsp_value !== want.value) begin
                  error_count++;
                  $display("%0t: value mismatch, expected %h actual %h",
                           $time, want.value, rsp_value);
               end
               if (rsp_equal !== want.equal) begin
                  error_count++;
                  $display("%0t: equal mismatch, expected %b actual %b",
                           $time, want.equal, rsp_equal);
               end
            end
         end
      end
      pending_count = predicted_words.size();
   end

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 100ps
// top of the montgomery modular alu testbench: stimulus, phases and verdict
module testbench;
   import mma_pkg::*;

   localparam int CYCLE_LIMIT  = 2000000;
   localparam int DRAIN_CYCLES = 50;
   localparam logic [3:0] CMD_UNUSED_LO = CMD_EQUAL + 4'd1;
   localparam logic [3:0] CMD_UNUSED_HI = 4'hF;
   localparam logic [63:0] INT64_MIN = 64'h8000_0000_0000_0000;
   localparam logic [63:0] INT64_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
   localparam logic [30:0] OP_MAX = 31'h7FFF_FFFF;

   logic               clock = 1'b0;
   logic               reset;
   logic               start;
   logic               busy;
   logic [3:0]         req_cmd;
   logic [30:0]        req_operand_a;
   logic [30:0]        req_operand_b;
   logic signed [63:0] req_plain_value;
   logic [63:0]        req_exponent;
   logic               csr_wr_en;
   logic [29:0]        csr_wr_data;
   logic               rsp_valid;
   logic [30:0]        rsp_value;
   logic               rsp_equal;

   int          error_count;
   int          pending_count;
   int          checked_count;
   int          cycle_count = 0;
   int          sender_idle_pct;
   int          words_sent;
   int          settings_used;
   logic [31:0] mod_now;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   montgomery_mod_alu_top u_dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_cmd         (req_cmd),
      .req_operand_a   (req_operand_a),
      .req_operand_b   (req_operand_b),
      .req_plain_value (req_plain_value),
      .req_exponent    (req_exponent),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data),
      .rsp_valid       (rsp_valid),
      .rsp_value       (rsp_value),
      .rsp_equal       (rsp_equal)
   );

   mma_checker u_checker (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_cmd         (req_cmd),
      .req_operand_a   (req_operand_a),
      .req_operand_b   (req_operand_b),
      .req_plain_value (req_plain_value),
      .req_exponent    (req_exponent),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data),
      .rsp_valid       (rsp_valid),
      .rsp_value       (rsp_value),
      .rsp_equal       (rsp_equal),
      .error_count     (error_count),
      .pending_count   (pending_count),
      .checked_count   (checked_count)
   );

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d words outstanding", cycle_count,
                  pending_count);
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // entered and left at a falling edge
   task automatic send_word(input logic [3:0] cmd, input logic [30:0] a,
                            input logic [30:0] b, input logic [63:0] plain,
                            input logic [63:0] e);
      while ($urandom_range(99, 0) < sender_idle_pct) begin
         start <= 1'b0;
         @(negedge clock);
      end
      req_cmd         <= cmd;
      req_operand_a   <= a;
      req_operand_b   <= b;
      req_plain_value <= plain;
      req_exponent    <= e;
      start           <= 1'b1;
      @(posedge clock);
      while (busy) @(posedge clock);
      words_sent++;
      @(negedge clock);
   endtask

   task automatic wait_idle;
      start <= 1'b0;
      while (pending_count != 0 || busy) @(negedge clock);
   endtask

   task automatic write_modulus(input logic [29:0] wr);
      wait_idle();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= wr;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      mod_now = {2'b00, wr[29:1], 1'b1};
      settings_used++;
   endtask

   function automatic logic [30:0] pick_operand();
      int sel;
      int corner;
      begin
         sel = $urandom_range(9, 0);
         if (sel == 0) begin
            return 31'($urandom);
         end else if (sel == 1) begin
            corner = $urandom_range(3, 0);
            case (corner)
               0: return 31'd0;
               1: return 31'(mod_now - 32'd1);
               2: return 31'(mod_now);
               default: return 31'((mod_now << 1) - 32'd1);
            endcase
         end
         return 31'({$urandom, $urandom} % {31'd0, mod_now, 1'b0});
      end
   endfunction

   function automatic logic [63:0] pick_plain();
      int sel;
      begin
         sel = $urandom_range(9, 0);
         if (sel < 5) return {$urandom, $urandom};
         if (sel < 8) return 64'(longint'($urandom_range(2000, 0)) - 64'sd1000);
         case ($urandom_range(3, 0))
            0: return INT64_MIN;
            1: return INT64_MAX;
            2: return 64'd0;
            default: return ~64'd0;
         endcase
      end
   endfunction

   function automatic logic [63:0] pick_exponent();
      int sel;
      begin
         sel = $urandom_range(9, 0);
         if (sel < 4) return 64'($urandom_range(65535, 0));
         if (sel < 8) return {$urandom, $urandom};
         case ($urandom_range(3, 0))
            0: return 64'd0;
            1: return 64'd1;
            2: return ~64'd0;
            default: return INT64_MIN;
         endcase
      end
   endfunction

   task automatic send_random;
      logic [3:0]  cmd;
      logic [30:0] a;
      logic [30:0] b;
      if ($urandom_range(99, 0) < 5) begin
         cmd = 4'($urandom_range(int'(CMD_UNUSED_HI), int'(CMD_UNUSED_LO)));
      end else begin
         cmd = 4'($urandom_range(int'(CMD_EQUAL), int'(CMD_FROM_PLAIN)));
      end
      a = pick_operand();
      b = pick_operand();
      // congruent pair for a good share of compares
      if (cmd == CMD_EQUAL && $urandom_range(9, 0) < 4) begin
         b = 31'({1'b0, a} % mod_now + (($urandom_range(1, 0) != 0) ? mod_now : 32'd0));
      end
      send_word(cmd, a, b, pick_plain(), pick_exponent());
   endtask

   task automatic run_phase(input logic [29:0] wr, input int idle_pct, input int count);
      write_modulus(wr);
      sender_idle_pct = idle_pct;
      repeat (count) send_random();
   endtask

   initial begin
      reset           = 1'b1;
      start           = 1'b0;
      req_cmd         = CMD_FROM_PLAIN;
      req_operand_a   = 31'd0;
      req_operand_b   = 31'd0;
      req_plain_value = 64'sd0;
      req_exponent    = 64'd0;
      csr_wr_en       = 1'b0;
      csr_wr_data     = 30'd0;
      sender_idle_pct = 0;
      words_sent      = 0;
      settings_used   = 1;
      mod_now         = {2'b00, MODULUS_RESET};
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed words at the reset modulus
      send_word(CMD_FROM_PLAIN, 31'd0, 31'd0, INT64_MIN, 64'd0);
      send_word(CMD_FROM_PLAIN, 31'd0, 31'd0, INT64_MAX, 64'd0);
      send_word(CMD_FROM_PLAIN, 31'd0, 31'd0, ~64'd0, 64'd0);
      send_word(CMD_FROM_PLAIN, OP_MAX, OP_MAX, 64'd0, ~64'd0);
      send_word(CMD_TO_PLAIN, 31'd0, 31'd0, 64'd0, 64'd0);
      send_word(CMD_TO_PLAIN, OP_MAX, 31'd0, 64'd0, 64'd0);
      send_word(CMD_TO_PLAIN, 31'(mod_now), 31'd0, 64'd0, 64'd0);
      send_word(CMD_ADD, OP_MAX, OP_MAX, 64'd0, 64'd0);
      send_word(CMD_ADD, 31'd0, 31'd0, 64'd0, 64'd0);
      send_word(CMD_SUB, 31'd0, OP_MAX, 64'd0, 64'd0);
      send_word(CMD_SUB, OP_MAX, 31'd0, 64'd0, 64'd0);
      send_word(CMD_MUL, OP_MAX, OP_MAX, 64'd0, 64'd0);
      // division by zero
      send_word(CMD_DIV, 31'd12345, 31'd0, 64'd0, 64'd0);
      send_word(CMD_DIV, OP_MAX, OP_MAX, 64'd0, 64'd0);
      send_word(CMD_NEG, 31'd0, 31'd0, 64'd0, 64'd0);
      send_word(CMD_NEG, OP_MAX, 31'd0, 64'd0, 64'd0);
      send_word(CMD_POW, OP_MAX, 31'd0, 64'd0, 64'd0);
      send_word(CMD_POW, 31'd123456789, 31'd0, 64'd0, ~64'd0);
      send_word(CMD_POW, 31'd0, 31'd0, 64'd0, 64'd1);
      send_word(CMD_INVERSE, 31'd0, 31'd0, 64'd0, 64'd0);
      send_word(CMD_INVERSE, OP_MAX, 31'd0, 64'd0, 64'd0);
      send_word(CMD_EQUAL, 31'd5, 31'(mod_now + 32'd5), 64'd0, 64'd0);
      send_word(CMD_EQUAL, 31'd0, OP_MAX, 64'd0, 64'd0);
      send_word(CMD_UNUSED_LO, OP_MAX, OP_MAX, ~64'd0, ~64'd0);
      send_word(CMD_UNUSED_HI, OP_MAX, OP_MAX, ~64'd0, ~64'd0);

      run_phase(30'h3FFF_FFFF, 81, 180);
      run_phase(30'd3, 6, 120);
      // even write of zero leaves modulus 1
      run_phase(30'd0, 0, 40);
      run_phase(30'($urandom), 81, 200);
      // even write that lands back on the reset prime
      run_phase(30'd998244352, 6, 210);
      run_phase(30'($urandom), 0, 200);

      wait_idle();
      repeat (DRAIN_CYCLES) @(negedge clock);

      $display("sent %0d command words over %0d modulus settings (1, 3, 2^30-1 among them)",
               words_sent, settings_used);
      $display("%0d result words compared, all commands and unused codes included",
               checked_count);
      if (error_count == 0 && pending_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
